>>> src/tfre_pkg.sv
// shared types, constants and helpers for the telemetry frame builder
`default_nettype none
package tfre_pkg;

  localparam int unsigned FRAME_LEN  = 20;
  localparam int unsigned IDX_W      = $clog2(FRAME_LEN);
  localparam int unsigned ANGLE_W    = 16;
  localparam int unsigned DIFF_W     = 18;
  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned QDEPTH     = 2;
  localparam int unsigned QPTR_W     = $clog2(QDEPTH);
  localparam int unsigned QCNT_W     = $clog2(QDEPTH + 1);

  localparam logic [CFG_IDX_W-1:0] REG_WRAP_SPAN      = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_WRAP_THRESHOLD = CFG_IDX_W'(1);

  localparam logic [CFG_DATA_W-1:0] WRAP_SPAN_RESET      = 16'd4000;
  localparam logic [CFG_DATA_W-1:0] WRAP_THRESHOLD_RESET = 16'd3000;

  localparam logic [7:0] SYNC_HI = 8'h5A;
  localparam logic [7:0] SYNC_LO = 8'hA5;
  localparam logic [7:0] TAIL_CR = 8'h0D;
  localparam logic [7:0] TAIL_LF = 8'h0A;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FRAME_LEN - 1);

  typedef struct packed {
    logic [31:0]        position;
    logic [31:0]        speed;
    logic [ANGLE_W-1:0] angle;
    logic [31:0]        rate;
    logic [7:0]         flag;
  } frame_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  function automatic logic [7:0] frame_byte_at(frame_t f, logic [IDX_W-1:0] idx);
    logic [7:0] b;
    b = 8'h00;
    case (idx)
      5'd0:    b = SYNC_HI;
      5'd1:    b = SYNC_LO;
      5'd2:    b = f.position[31:24];
      5'd3:    b = f.position[23:16];
      5'd4:    b = f.position[15:8];
      5'd5:    b = f.position[7:0];
      5'd6:    b = f.speed[31:24];
      5'd7:    b = f.speed[23:16];
      5'd8:    b = f.speed[15:8];
      5'd9:    b = f.speed[7:0];
      5'd10:   b = f.angle[15:8];
      5'd11:   b = f.angle[7:0];
      5'd12:   b = f.rate[31:24];
      5'd13:   b = f.rate[23:16];
      5'd14:   b = f.rate[15:8];
      5'd15:   b = f.rate[7:0];
      5'd16:   b = f.flag;
      5'd17:   b = f.flag;
      5'd18:   b = TAIL_CR;
      5'd19:   b = TAIL_LF;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage
`default_nettype wire

>>> src/tfre_if.sv
// channel interfaces: tick input, frame byte output, register writes
`default_nettype none
interface tfre_in_if #(parameter int unsigned ANGLE_BITS = 12);
  logic                  valid;
  logic                  ready;
  logic [31:0]           cart_position;
  logic [ANGLE_BITS-1:0] angle_sample;
  logic [7:0]            status_flag;
  modport source (output valid, output cart_position, output angle_sample,
                  output status_flag, input ready);
  modport sink   (input valid, input cart_position, input angle_sample,
                  input status_flag, output ready);
endinterface

interface tfre_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic       frame_last;
  modport source (output valid, output frame_byte, output frame_last, input ready);
  modport sink   (input valid, input frame_byte, input frame_last, output ready);
endinterface

interface tfre_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  index;
  logic [15:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

>>> src/tfre_front.sv
// front end: config registers, tick accept, speed and angular rate, queue push
`default_nettype none
module tfre_front #(
  parameter int unsigned ANGLE_BITS = 12
) (
  input  wire                   clk,
  input  wire                   rst_n,
  tfre_in_if.sink               in_ch,
  tfre_cfg_if.sink              cfg_ch,
  input  tfre_pkg::q_status_t   q_status,
  output logic                  push,
  output tfre_pkg::frame_t      push_data
);
  import tfre_pkg::*;

  logic [CFG_DATA_W-1:0] wrap_span_r;
  logic [CFG_DATA_W-1:0] wrap_thr_r;
  logic [31:0]           last_pos_r;
  logic [ANGLE_BITS-1:0] last_ang_r;

  logic signed [DIFF_W-1:0] diff;
  logic signed [DIFF_W-1:0] thr_s;
  logic signed [DIFF_W-1:0] span_s;
  logic signed [DIFF_W-1:0] step1;
  logic signed [DIFF_W-1:0] step2;

  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = !q_status.full;
  assign push         = in_ch.valid && !q_status.full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wrap_span_r <= WRAP_SPAN_RESET;
      wrap_thr_r  <= WRAP_THRESHOLD_RESET;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        REG_WRAP_SPAN:      wrap_span_r <= cfg_ch.data;
        REG_WRAP_THRESHOLD: wrap_thr_r  <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  // wrap-corrected angle difference
  always_comb begin
    diff   = signed'(DIFF_W'(in_ch.angle_sample)) - signed'(DIFF_W'(last_ang_r));
    thr_s  = signed'(DIFF_W'(wrap_thr_r));
    span_s = signed'(DIFF_W'(wrap_span_r));
    step1  = (diff > thr_s) ? (diff - span_s) : diff;
    step2  = (step1 < -thr_s) ? (step1 + span_s) : step1;
  end

  always_comb begin
    push_data.position = in_ch.cart_position;
    push_data.speed    = in_ch.cart_position - last_pos_r;
    push_data.angle    = ANGLE_W'(in_ch.angle_sample);
    push_data.rate     = {{(32-DIFF_W){step2[DIFF_W-1]}}, step2};
    push_data.flag     = in_ch.status_flag;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_pos_r <= '0;
      last_ang_r <= '0;
    end else if (push) begin
      last_pos_r <= in_ch.cart_position;
      last_ang_r <= in_ch.angle_sample;
    end
  end

endmodule
`default_nettype wire

>>> src/tfre_fifo.sv
// short frame queue between front end and serializer
`default_nettype none
module tfre_fifo (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   push,
  input  tfre_pkg::frame_t      push_data,
  input  wire                   pop,
  output tfre_pkg::frame_t      head,
  output tfre_pkg::q_status_t   status
);
  import tfre_pkg::*;

  frame_t            mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] count_r;
  logic              do_push;
  logic              do_pop;

  assign status.full  = (count_r == QCNT_W'(QDEPTH));
  assign status.empty = (count_r == '0);
  assign do_push      = push && !status.full;
  assign do_pop       = pop && !status.empty;
  assign head         = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

>>> src/tfre_back.sv
// back end: serializes one queued frame into twenty output beats
`default_nettype none
module tfre_back (
  input  wire                   clk,
  input  wire                   rst_n,
  input  tfre_pkg::frame_t      head,
  input  tfre_pkg::q_status_t   q_status,
  output logic                  pop,
  tfre_out_if.source            out_ch
);
  import tfre_pkg::*;

  frame_t           frame_r;
  logic [IDX_W-1:0] idx_r;
  logic             active_r;
  logic             out_valid_r;
  logic [7:0]       out_byte_r;
  logic             out_last_r;
  logic             adv;
  logic             finishing;

  assign adv       = !out_valid_r || out_ch.ready;
  assign finishing = active_r && adv && (idx_r == LAST_IDX);
  assign pop       = !q_status.empty && (!active_r || finishing);

  assign out_ch.valid      = out_valid_r;
  assign out_ch.frame_byte = out_byte_r;
  assign out_ch.frame_last = out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= 1'b0;
      out_valid_r <= 1'b0;
      idx_r       <= '0;
    end else begin
      if (adv) begin
        out_valid_r <= active_r;
      end
      if (pop) begin
        active_r <= 1'b1;
        idx_r    <= '0;
      end else if (finishing) begin
        active_r <= 1'b0;
      end else if (active_r && adv) begin
        idx_r <= idx_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      frame_r <= head;
    end
    if (adv && active_r) begin
      out_byte_r <= frame_byte_at(frame_r, idx_r);
      out_last_r <= (idx_r == LAST_IDX);
    end
  end

endmodule
`default_nettype wire

>>> src/telemetry_frame_with_rate_estimate.sv
// top level: telemetry frame builder with cart speed and angular rate
//
// in_ch takes one report tick per beat (cart position, angle sample, status
// byte). out_ch sends the 20-byte big-endian frame for that tick, one byte
// per beat, frame_last high on the final 0D 0A byte. cfg_ch writes
// wrap_span (index 0) and wrap_threshold (index 1); other indexes are
// dropped; cfg_ch is always ready.
// A tick is written into the frame queue, popped into the serializer's
// frame register, and each byte is registered before out_ch. The
// serializer sends one byte per cycle while out_ch is ready; a two-entry frame
// queue lets ticks be taken while an earlier frame is still going out.
// Reset clears the previous position and angle to zero, loads wrap_span
// with 4000 and wrap_threshold with 3000, and empties the queue.
// When out_ch stalls the current byte holds; once the queue fills, in_ch
// ready drops until a frame finishes.
`default_nettype none
module telemetry_frame_with_rate_estimate #(
  parameter int unsigned ANGLE_BITS = 12
) (
  input  wire  clk,
  input  wire  rst_n,
  tfre_in_if.sink    in_ch,
  tfre_out_if.source out_ch,
  tfre_cfg_if.sink   cfg_ch
);
  import tfre_pkg::*;

  q_status_t q_status;
  logic      push;
  logic      pop;
  frame_t    push_data;
  frame_t    head;

  tfre_front #(.ANGLE_BITS(ANGLE_BITS)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .cfg_ch    (cfg_ch),
    .q_status  (q_status),
    .push      (push),
    .push_data (push_data)
  );

  tfre_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .status    (q_status)
  );

  tfre_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .head     (head),
    .q_status (q_status),
    .pop      (pop),
    .out_ch   (out_ch)
  );

endmodule
`default_nettype wire

>>> verif/tb_top.sv
// testbench for the telemetry frame builder: tick driver, frame byte checker, register writes
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import tfre_pkg::*;

  localparam int unsigned ANGLE_BITS  = 12;
  localparam int unsigned FRAME_BYTES = 20;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned MAX_PRINTS  = 50;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LO = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_HI = '1;

  typedef struct {
    logic [31:0]           position;
    logic [ANGLE_BITS-1:0] angle;
    logic [7:0]            flag;
  } tick_t;

  typedef struct {
    logic [7:0] data;
    logic       is_last;
  } frame_beat_t;

  logic clk;
  logic rst_n;

  tfre_in_if #(.ANGLE_BITS(ANGLE_BITS)) in_ch ();
  tfre_out_if out_ch ();
  tfre_cfg_if cfg_ch ();

  telemetry_frame_with_rate_estimate #(.ANGLE_BITS(ANGLE_BITS)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  tick_t       tick_q[$];
  frame_beat_t frame_q[$];
  int          ticks_left;
  int          err_cnt;
  int          gap_pct;
  int          stall_pct;
  int unsigned cycle_cnt;

  logic [15:0]           span_cfg;
  logic [15:0]           thr_cfg;
  logic [31:0]           prev_position;
  logic [ANGLE_BITS-1:0] prev_angle;

  logic [31:0]           gen_pos;
  logic [ANGLE_BITS-1:0] gen_ang;

  tick_t       drv_tick;
  frame_beat_t mon_beat;

  always #5 clk = ~clk;

  task automatic report_mismatch(input string msg);
    if (err_cnt < MAX_PRINTS) $display("mismatch at %0t: %s", $realtime, msg);
    err_cnt++;
  endtask

  function automatic void predict_frame(input tick_t t);
    logic [31:0]  speed;
    logic [31:0]  rate;
    logic [159:0] fv;
    int           d;
    speed = t.position - prev_position;
    d = int'(t.angle) - int'(prev_angle);
    if (d > int'(thr_cfg)) d -= int'(span_cfg);
    if (d < -int'(thr_cfg)) d += int'(span_cfg);
    rate = d;
    prev_position = t.position;
    prev_angle = t.angle;
    fv = {SYNC_HI, SYNC_LO, t.position, speed, 16'(t.angle), rate,
          t.flag, t.flag, TAIL_CR, TAIL_LF};
    for (int k = 0; k < FRAME_BYTES; k++) begin
      frame_q.push_back('{data: fv[159 - 8*k -: 8], is_last: (k == FRAME_BYTES - 1)});
    end
  endfunction

  // tick driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        predict_frame(drv_tick);
        ticks_left--;
      end
      if (!(in_ch.valid && !in_ch.ready)) begin
        if (tick_q.size() != 0 && $urandom_range(99) >= gap_pct) begin
          drv_tick = tick_q.pop_front();
          in_ch.valid         <= 1'b1;
          in_ch.cart_position <= drv_tick.position;
          in_ch.angle_sample  <= drv_tick.angle;
          in_ch.status_flag   <= drv_tick.flag;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // frame byte monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (frame_q.size() == 0) begin
          report_mismatch($sformatf("unexpected beat %02h last %0b",
                                    out_ch.frame_byte, out_ch.frame_last));
        end else begin
          mon_beat = frame_q.pop_front();
          if (out_ch.frame_byte !== mon_beat.data)
            report_mismatch($sformatf("frame_byte %02h exp %02h",
                                      out_ch.frame_byte, mon_beat.data));
          if (out_ch.frame_last !== mon_beat.is_last)
            report_mismatch($sformatf("frame_last %0b exp %0b",
                                      out_ch.frame_last, mon_beat.is_last));
        end
      end
      out_ch.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
    @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    if (idx == REG_WRAP_SPAN) span_cfg = val;
    else if (idx == REG_WRAP_THRESHOLD) thr_cfg = val;
  endtask

  task automatic add_tick(input logic [31:0] pos, input logic [ANGLE_BITS-1:0] ang,
                          input logic [7:0] flag);
    tick_q.push_back('{position: pos, angle: ang, flag: flag});
    ticks_left++;
    gen_pos = pos;
    gen_ang = ang;
  endtask

  task automatic add_random_ticks(input int n);
    logic [31:0]           pos;
    logic [ANGLE_BITS-1:0] ang;
    int                    delta;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(3))
        0: begin
          pos = $urandom;
          ang = $urandom_range(4095);
        end
        1: begin
          pos = gen_pos + $urandom_range(64) - 32;
          ang = ANGLE_BITS'(int'(gen_ang) + int'($urandom_range(40)) - 20);
        end
        2: begin
          // jumps around the threshold and the span
          pos = gen_pos + $urandom_range(4096);
          if ($urandom_range(1)) delta = int'(thr_cfg) + int'($urandom_range(2)) - 1;
          else delta = int'(span_cfg) - int'($urandom_range(3));
          if ($urandom_range(1)) delta = -delta;
          ang = ANGLE_BITS'(int'(gen_ang) + delta);
        end
        default: begin
          pos = $urandom_range(1) ? 32'hFFFF_FFF0 + $urandom_range(15) : $urandom_range(15);
          ang = $urandom_range(4095);
        end
      endcase
      add_tick(pos, ang, 8'($urandom_range(255)));
    end
  endtask

  task automatic wait_drained();
    while (ticks_left != 0 || frame_q.size() != 0) @(posedge clk);
  endtask

  int unsigned span_set[6];
  int unsigned thr_set[6];
  int          gap_set[4];
  int          stall_set[4];

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.cart_position = '0;
    in_ch.angle_sample = '0;
    in_ch.status_flag = '0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    ticks_left = 0;
    err_cnt = 0;
    cycle_cnt = 0;
    gap_pct = 0;
    stall_pct = 0;
    span_cfg = WRAP_SPAN_RESET;
    thr_cfg = WRAP_THRESHOLD_RESET;
    prev_position = '0;
    prev_angle = '0;
    gen_pos = '0;
    gen_ang = '0;
    span_set = '{4000, 0, 65535, 1, 4096, 0};
    thr_set = '{3000, 100, 0, 65535, 2047, 0};
    gap_set = '{0, 86, 0, 12};
    stall_set = '{0, 0, 86, 12};
    span_set[5] = $urandom_range(65535);
    thr_set[5] = $urandom_range(65535);

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings, first tick against zero
    add_tick(32'h0000_0010, 12'd3500, 8'h00);
    add_tick(32'hFFFF_FFFF, 12'd4095, 8'hFF);
    add_tick(32'h0000_0000, 12'd0, 8'hA5);
    add_tick(32'h0000_0000, 12'd3000, 8'h01);
    add_tick(32'h0000_0001, 12'd0, 8'h02);
    add_tick(32'h0000_0002, 12'd3001, 8'h04);
    add_tick(32'h0000_0003, 12'd0, 8'h08);
    add_tick(32'h8000_0000, 12'd4095, 8'h80);
    add_tick(32'h7FFF_FFFF, 12'd4094, 8'h7F);
    add_tick(32'h5555_5555, 12'h555, 8'h55);
    add_tick(32'hAAAA_AAAA, 12'hAAA, 8'hAA);
    add_tick(32'hAAAA_AAAA, 12'hAAA, 8'hAA);
    wait_drained();

    // zero threshold with full span: both corrections in one tick
    write_reg(REG_WRAP_SPAN, 16'hFFFF);
    write_reg(REG_WRAP_THRESHOLD, 16'h0000);
    write_reg(REG_UNUSED_LO, 16'h1234);
    write_reg(REG_UNUSED_HI, 16'hFFFF);
    add_tick(32'h0000_0100, 12'hAAF, 8'h11);
    add_tick(32'h0000_00FF, 12'hAAA, 8'h22);
    add_tick(32'h0000_00FF, 12'hAAA, 8'h33);
    add_tick(32'h1234_5678, 12'h000, 8'h44);
    wait_drained();

    // zero span
    write_reg(REG_WRAP_SPAN, 16'h0000);
    add_tick(32'h0000_0000, 12'd4095, 8'hC3);
    add_tick(32'h0000_0001, 12'd0, 8'h3C);
    add_tick(32'hFFFF_FFFE, 12'd7, 8'h0F);
    wait_drained();

    for (int s = 0; s < 6; s++) begin
      write_reg(REG_WRAP_SPAN, 16'(span_set[s]));
      write_reg(REG_WRAP_THRESHOLD, 16'(thr_set[s]));
      for (int m = 0; m < 4; m++) begin
        gap_pct = gap_set[m];
        stall_pct = stall_set[m];
        add_random_ticks(17);
        wait_drained();
      end
    end

    wait_drained();
    repeat (40) @(posedge clk);
    if (frame_q.size() != 0) report_mismatch("expected beats left over");
    if (err_cnt == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

>>> files.f
src/tfre_pkg.sv
src/tfre_if.sv
src/tfre_front.sv
src/tfre_fifo.sv
src/tfre_back.sv
src/telemetry_frame_with_rate_estimate.sv
verif/tb_top.sv
